@@ design/assert_macros.svh @@
// Assertion macros used by the RTL. Each macro has an empty twin that is
// used when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A condition in one cycle that forces a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/pvcq_pkg.sv @@
`default_nettype none

package pvcq_pkg;

   localparam int QUEUE_DEPTH       = 10;
   localparam int MAX_MESSAGE_BYTES = 6;
   localparam int EVT_FIFO_DEPTH    = 2;
   localparam int RSP_FIFO_DEPTH    = 4;
   localparam int POS_WIDTH         = 3;

   localparam logic [15:0] ASCII_ZERO = 16'd48;
   localparam logic [7:0]  DASH_CODE  = 8'd45;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      EVT_CMD = 2'd0,
      EVT_BAD = 2'd1,
      EVT_POP = 2'd2
   } evt_kind_type;

   typedef enum logic [2:0] {
      ST_QUEUED    = 3'd0,
      ST_MALFORMED = 3'd1,
      ST_FULL      = 3'd2,
      ST_POPPED    = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      evt_kind_type       kind;
      logic signed [15:0] pin;
      logic signed [15:0] level;
   } evt_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] pin;
      logic signed [15:0] level;
      logic [3:0]         count;
   } rsp_type;

   // Multiply by ten and add a digit, wrapping at 16 bits.
   function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [15:0] dig);
      return (acc << 3) + (acc << 1) + dig;
   endfunction

endpackage

`default_nettype wire

@@ design/pvcq_fifo.sv @@
`default_nettype none

module pvcq_fifo #(
   parameter int Depth = pvcq_pkg::EVT_FIFO_DEPTH,
   parameter int Width = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [Width-1:0]           wr_data,
   output logic                            full,
   input  wire logic                       pop,
   output logic [Width-1:0]                rd_data,
   output logic                            empty,
   output logic [$clog2(Depth+1)-1:0]      count
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] entries_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ design/pvcq_front.sv @@
`default_nettype none

module pvcq_front #(
   parameter int MaxMessageBytes = pvcq_pkg::MAX_MESSAGE_BYTES
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic           operation,
   input  wire logic [7:0]     char_byte,
   input  wire logic           end_of_message,
   output logic                evt_valid,
   output pvcq_pkg::evt_type   evt
);

   logic [15:0]                        running_ff, running_in;
   logic [15:0]                        pin_ff, pin_in;
   logic [15:0]                        after_ff, after_in;
   logic                               dash_ff, dash_in;
   logic                               long_ff, long_in;
   logic [pvcq_pkg::POS_WIDTH-1:0]     pos_ff, pos_in;
   logic [15:0]                        digit;

   assign digit = {8'd0, char_byte} - pvcq_pkg::ASCII_ZERO;

   always_comb begin
      running_in = running_ff;
      pin_in     = pin_ff;
      after_in   = after_ff;
      dash_in    = dash_ff;
      long_in    = long_ff;
      pos_in     = pos_ff;
      evt_valid  = 1'b0;
      evt        = '{kind: pvcq_pkg::EVT_POP, pin: '0, level: '0};

      if (accept && (operation == pvcq_pkg::OP_BYTE)) begin
         if (pos_ff >= pvcq_pkg::POS_WIDTH'(MaxMessageBytes)) begin
            long_in = 1'b1;
         end else begin
            if (char_byte == pvcq_pkg::DASH_CODE) begin
               if (pos_ff != '0) begin
                  dash_in = 1'b1;
               end
               pin_in   = running_ff;
               after_in = '0;
            end else begin
               after_in = pvcq_pkg::acc_digit(after_ff, digit);
            end
            running_in = pvcq_pkg::acc_digit(running_ff, digit);
            pos_in     = pos_ff + 1'b1;
         end

         if (end_of_message) begin
            evt_valid = 1'b1;
            if (long_in || !dash_in) begin
               evt.kind = pvcq_pkg::EVT_BAD;
            end else begin
               evt.kind  = pvcq_pkg::EVT_CMD;
               evt.pin   = pin_in;
               evt.level = after_in;
            end
            running_in = '0;
            pin_in     = '0;
            after_in   = '0;
            dash_in    = 1'b0;
            long_in    = 1'b0;
            pos_in     = '0;
         end
      end else if (accept) begin
         evt_valid = 1'b1;
         evt.kind  = pvcq_pkg::EVT_POP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         pin_ff     <= '0;
         after_ff   <= '0;
         dash_ff    <= 1'b0;
         long_ff    <= 1'b0;
         pos_ff     <= '0;
      end else begin
         running_ff <= running_in;
         pin_ff     <= pin_in;
         after_ff   <= after_in;
         dash_ff    <= dash_in;
         long_ff    <= long_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ design/pvcq_back.sv @@
`default_nettype none

`include "assert_macros.svh"

module pvcq_back #(
   parameter int QueueDepth = pvcq_pkg::QUEUE_DEPTH,
   parameter int RspDepth   = pvcq_pkg::RSP_FIFO_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          evt_empty,
   input  wire pvcq_pkg::evt_type             evt,
   output logic                               evt_pop,
   input  wire logic [$clog2(RspDepth+1)-1:0] rsp_count,
   output logic                               rsp_push,
   output pvcq_pkg::rsp_type                  rsp
);

   localparam int IdxW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int FillW = $clog2(QueueDepth + 1);
   localparam int CntW  = $clog2(RspDepth + 1);

   logic [31:0]          store_ff [QueueDepth];
   logic [31:0]          rd_ff;
   logic [IdxW-1:0]      head_ff, head_in;
   logic [IdxW-1:0]      tail_ff, tail_in;
   logic [FillW-1:0]     fill_ff, fill_in;
   logic                 take, do_write, do_read;

   logic                 s2_valid_ff;
   logic                 s2_use_mem_ff, s2_use_mem_in;
   pvcq_pkg::rsp_type    s2_ff, s2_in;

   // A response slot is reserved for the item in the second stage.
   assign take    = !evt_empty &&
                    ((CntW + 1)'(rsp_count) + (CntW + 1)'(s2_valid_ff) < (CntW + 1)'(RspDepth));
   assign evt_pop = take;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      do_write      = 1'b0;
      do_read       = 1'b0;
      s2_use_mem_in = 1'b0;
      s2_in         = '{status: pvcq_pkg::ST_EMPTY, pin: '0, level: '0, count: '0};

      if (take) begin
         case (evt.kind)
            pvcq_pkg::EVT_POP: begin
               if (fill_ff == '0) begin
                  s2_in.status = pvcq_pkg::ST_EMPTY;
               end else begin
                  s2_in.status  = pvcq_pkg::ST_POPPED;
                  s2_use_mem_in = 1'b1;
                  do_read       = 1'b1;
                  head_in = (head_ff == IdxW'(QueueDepth - 1)) ? '0 : head_ff + 1'b1;
                  fill_in = fill_ff - 1'b1;
               end
            end
            pvcq_pkg::EVT_CMD: begin
               s2_in.pin   = evt.pin;
               s2_in.level = evt.level;
               if (fill_ff == FillW'(QueueDepth)) begin
                  s2_in.status = pvcq_pkg::ST_FULL;
               end else begin
                  s2_in.status = pvcq_pkg::ST_QUEUED;
                  do_write     = 1'b1;
                  tail_in = (tail_ff == IdxW'(QueueDepth - 1)) ? '0 : tail_ff + 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
            default: begin
               s2_in.status = pvcq_pkg::ST_MALFORMED;
            end
         endcase
         s2_in.count = 4'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fill_ff     <= fill_in;
         s2_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff         <= s2_in;
      s2_use_mem_ff <= s2_use_mem_in;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         store_ff[tail_ff] <= {evt.pin, evt.level};
      end
      if (do_read) begin
         rd_ff <= store_ff[head_ff];
      end
   end

   always_comb begin
      rsp = s2_ff;
      if (s2_use_mem_ff) begin
         rsp.pin   = rd_ff[31:16];
         rsp.level = rd_ff[15:0];
      end
   end

   assign rsp_push = s2_valid_ff;

   `ASSERT_ALWAYS(a_rsp_room, !s2_valid_ff || (rsp_count < CntW'(RspDepth)), "response queue overrun")
   `ASSERT_ALWAYS(a_fill_bound, fill_ff <= FillW'(QueueDepth), "command queue fill out of range")
   `ASSERT_ALWAYS(a_head_bound, head_ff < IdxW'(QueueDepth) || QueueDepth == 1, "head out of range")
   `ASSERT_NEXT(a_pop_drains, take && evt.kind == pvcq_pkg::EVT_POP && fill_ff != '0, fill_ff == $past(fill_ff) - 1'b1, "pop did not drain the queue")

endmodule

`default_nettype wire

@@ design/pin_value_command_parser_queue_top.sv @@
// A result passes through the event queue, the execute stage register and the result
// queue before it is visible on the response ports. Throughput: one transaction per
// cycle while full is low, with at most one command-store access per cycle.
// Reset is synchronous and active high: it clears the parser, the queue pointers and both
// internal queues; the command store itself is not cleared and is only read once written.
`default_nettype none

module pin_value_command_parser_queue_top #(
   parameter int QueueDepth      = pvcq_pkg::QUEUE_DEPTH,
   parameter int MaxMessageBytes = pvcq_pkg::MAX_MESSAGE_BYTES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request side: a transaction is taken when push is high and full is low.
   input  wire logic               push,
   output logic                    full,
   input  wire logic               req_operation,
   input  wire logic [7:0]         req_char_byte,
   input  wire logic               req_end_of_message,
   // Response side: the oldest result is shown while empty is low.
   output logic                    empty,
   input  wire logic               pop,
   output logic [2:0]              rsp_status,
   output logic signed [15:0]      rsp_pin_number,
   output logic signed [15:0]      rsp_output_level,
   output logic [3:0]              rsp_queue_count
);

   localparam int EvtW = $bits(pvcq_pkg::evt_type);
   localparam int RspW = $bits(pvcq_pkg::rsp_type);

   logic                                          accept;
   logic                                          evt_valid;
   pvcq_pkg::evt_type                             evt_front;
   logic [EvtW-1:0]                               evt_raw;
   logic                                          evt_empty;
   logic                                          evt_pop;
   logic [$clog2(pvcq_pkg::EVT_FIFO_DEPTH+1)-1:0] evt_count;
   logic                                          rsp_push;
   pvcq_pkg::rsp_type                             rsp_back;
   pvcq_pkg::rsp_type                             rsp_head;
   logic [RspW-1:0]                               rsp_raw;
   logic                                          rsp_full;
   logic [$clog2(pvcq_pkg::RSP_FIFO_DEPTH+1)-1:0] rsp_count;

   // Every request transaction is taken as soon as the event queue has a free slot,
   // whether or not it will end up producing a result.
   assign accept = push && !full;

   // The front end runs the parser on each byte and emits one event per finished
   // message or per pop request.
   pvcq_front #(
      .MaxMessageBytes(MaxMessageBytes)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .operation     (req_operation),
      .char_byte     (req_char_byte),
      .end_of_message(req_end_of_message),
      .evt_valid     (evt_valid),
      .evt           (evt_front)
   );

   // Short event queue that decouples the parser from the command execute stage.
   pvcq_fifo #(
      .Depth(pvcq_pkg::EVT_FIFO_DEPTH),
      .Width(EvtW)
   ) u_evt_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (evt_valid),
      .wr_data(evt_front),
      .full   (full),
      .pop    (evt_pop),
      .rd_data(evt_raw),
      .empty  (evt_empty),
      .count  (evt_count)
   );

   // The back end owns the command store and turns each event into one result.
   pvcq_back #(
      .QueueDepth(QueueDepth),
      .RspDepth  (pvcq_pkg::RSP_FIFO_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .evt_empty(evt_empty),
      .evt      (pvcq_pkg::evt_type'(evt_raw)),
      .evt_pop  (evt_pop),
      .rsp_count(rsp_count),
      .rsp_push (rsp_push),
      .rsp      (rsp_back)
   );

   // Result queue; the back end reserves room before it starts an event, so a
   // finished result never waits on the consumer.
   pvcq_fifo #(
      .Depth(pvcq_pkg::RSP_FIFO_DEPTH),
      .Width(RspW)
   ) u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(rsp_back),
      .full   (rsp_full),
      .pop    (pop),
      .rd_data(rsp_raw),
      .empty  (empty),
      .count  (rsp_count)
   );

   assign rsp_head         = pvcq_pkg::rsp_type'(rsp_raw);
   assign rsp_status       = rsp_head.status;
   assign rsp_pin_number   = rsp_head.pin;
   assign rsp_output_level = rsp_head.level;
   assign rsp_queue_count  = rsp_head.count;

   // The occupancy of the event queue and the full flag of the result queue are
   // not needed for control; they are folded here so nothing is left dangling.
   logic unused_ok;
   assign unused_ok = ^{evt_count, rsp_full};

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
module tb_top;
   import pvcq_pkg::*;

   // Stimulus sizing. The random part stops once this many transactions went in.
   localparam int ITEM_TARGET = 1100;
   // Length of each long receiver hold-off, in clock cycles.
   localparam int HOLD_CYCLES = 400;

   logic               clock;
   logic               reset              = 1'b1;
   logic               push               = 1'b0;
   logic               req_operation      = OP_BYTE;
   logic [7:0]         req_char_byte      = 8'h00;
   logic               req_end_of_message = 1'b0;
   logic               pop                = 1'b0;
   logic               full;
   logic               empty;
   logic [2:0]         rsp_status;
   logic signed [15:0] rsp_pin_number;
   logic signed [15:0] rsp_output_level;
   logic [3:0]         rsp_queue_count;

   pin_value_command_parser_queue_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_operation      (req_operation),
      .req_char_byte      (req_char_byte),
      .req_end_of_message (req_end_of_message),
      .empty              (empty),
      .pop                (pop),
      .rsp_status         (rsp_status),
      .rsp_pin_number     (rsp_pin_number),
      .rsp_output_level   (rsp_output_level),
      .rsp_queue_count    (rsp_queue_count)
   );

   // One row of the directed part. Rows whose outcome is obvious carry their
   // expected result typed in; every other row relies on the command predictor.
   typedef struct {
      logic       op;
      logic [7:0] ch;
      logic       eom;
      bit         has_fixed;
      rsp_type    fixed;
   } stim_row_type;

   stim_row_type directed_rows[$];
   rsp_type      expected_results[$];

   int items_sent     = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int full_cycles    = 0;
   int status_tally[8];

   // Our own copy of the parser state and the command store. These start at
   // their reset values, and reset is applied exactly once, at the start.
   logic [15:0] msg_value  = '0;
   logic [15:0] pin_part   = '0;
   logic [15:0] value_part = '0;
   bit          dash_ok    = 1'b0;
   int          msg_bytes  = 0;
   bit          overlong   = 1'b0;
   logic [15:0] stored_pin[QUEUE_DEPTH];
   logic [15:0] stored_level[QUEUE_DEPTH];
   int          q_head     = 0;
   int          q_held     = 0;

   // Every received byte counts as its code minus 48, and the running
   // number is scaled by ten first. Everything wraps at 16 bits.
   function automatic logic [15:0] times_ten_plus(input logic [15:0] acc, input logic [7:0] ch);
      return acc * 16'd10 + ({8'h00, ch} - ASCII_ZERO);
   endfunction

   function automatic logic [7:0] numeral(input int n);
      return ASCII_ZERO[7:0] + 8'(n);
   endfunction

   // Advances the predicted state by one accepted transaction and reports the
   // result that it should cause, if any.
   function automatic void predict_command(input logic op, input logic [7:0] ch,
                                           input logic eom, output bit produced,
                                           output rsp_type r);
      int tail;
      produced = 1'b0;
      r = '0;
      if (op == OP_POP) begin
         // A pop never touches the parser, even in the middle of a message.
         produced = 1'b1;
         if (q_held == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.status = ST_POPPED;
            r.pin    = stored_pin[q_head];
            r.level  = stored_level[q_head];
            q_head   = (q_head + 1) % QUEUE_DEPTH;
            q_held--;
         end
         r.count = 4'(q_held);
         return;
      end
      // Past the buffer size the message is only marked as too long.
      if (msg_bytes >= MAX_MESSAGE_BYTES) begin
         overlong = 1'b1;
      end else begin
         if (ch == DASH_CODE) begin
            if (msg_bytes != 0) dash_ok = 1'b1;
            pin_part   = msg_value;
            value_part = '0;
         end else begin
            value_part = times_ten_plus(value_part, ch);
         end
         msg_value = times_ten_plus(msg_value, ch);
         msg_bytes++;
      end
      if (!eom) return;
      produced = 1'b1;
      if (overlong || !dash_ok) begin
         r.status = ST_MALFORMED;
      end else if (q_held >= QUEUE_DEPTH) begin
         // The store is full: the parsed command is reported and dropped.
         r.status = ST_FULL;
         r.pin    = pin_part;
         r.level  = value_part;
      end else begin
         tail               = (q_head + q_held) % QUEUE_DEPTH;
         stored_pin[tail]   = pin_part;
         stored_level[tail] = value_part;
         q_held++;
         r.status = ST_QUEUED;
         r.pin    = pin_part;
         r.level  = value_part;
      end
      r.count    = 4'(q_held);
      msg_value  = '0;
      pin_part   = '0;
      value_part = '0;
      dash_ok    = 1'b0;
      msg_bytes  = 0;
      overlong   = 1'b0;
   endfunction

   function automatic void add_byte(input logic [7:0] ch, input logic eom);
      stim_row_type row;
      row.op        = OP_BYTE;
      row.ch        = ch;
      row.eom       = eom;
      row.has_fixed = 1'b0;
      row.fixed     = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_known(input logic op, input logic [7:0] ch, input logic eom,
                                     input rsp_type fixed);
      stim_row_type row;
      row.op        = op;
      row.ch        = ch;
      row.eom       = eom;
      row.has_fixed = 1'b1;
      row.fixed     = fixed;
      directed_rows.push_back(row);
   endfunction

   // Offers one transaction after a random gap and holds it until the block
   // takes it. The expectation is queued at the very edge of acceptance.
   // In every 200 transactions the first 40 go without any gap.
   task automatic send_item(input logic op, input logic [7:0] ch, input logic eom,
                            input bit has_fixed, input rsp_type fixed);
      int      gap;
      bit      produced;
      rsp_type predicted;
      gap = (items_sent % 200 < 40) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push               <= 1'b1;
      req_operation      <= op;
      req_char_byte      <= ch;
      req_end_of_message <= eom;
      forever begin
         @(posedge clock);
         if (!full) break;
         full_cycles++;
      end
      predict_command(op, ch, eom, produced, predicted);
      if (produced) expected_results.push_back(has_fixed ? fixed : predicted);
      items_sent++;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stimulus: the directed rows first, then random messages and pops.
   initial begin
      int         kind;
      int         len;
      int         pin_len;
      int         split;
      int         pop_percent;
      logic [7:0] body[$];
      rsp_type    none;
      none = '0;

      // Pop on an empty queue right after reset. The byte fields are ignored.
      add_known(OP_POP, 8'h00, 1'b0, '{ST_EMPTY, 16'sd0, 16'sd0, 4'd0});
      // A plain well-formed command.
      add_byte(numeral(3), 1'b0);
      add_byte(DASH_CODE, 1'b0);
      add_known(OP_BYTE, numeral(1), 1'b1, '{ST_QUEUED, 16'sd3, 16'sd1, 4'd1});
      // A dash in the first position does not make a message valid.
      add_byte(DASH_CODE, 1'b0);
      add_known(OP_BYTE, numeral(5), 1'b1, '{ST_MALFORMED, 16'sd0, 16'sd0, 4'd1});
      // A single byte with no dash at all.
      add_known(OP_BYTE, numeral(7), 1'b1, '{ST_MALFORMED, 16'sd0, 16'sd0, 4'd1});
      // One byte more than the buffer holds.
      add_byte(numeral(1), 1'b0);
      add_byte(DASH_CODE, 1'b0);
      for (int n = 2; n <= 5; n++) add_byte(numeral(n), 1'b0);
      add_known(OP_BYTE, numeral(6), 1'b1, '{ST_MALFORMED, 16'sd0, 16'sd0, 4'd1});
      // Exactly a full buffer, with the extreme byte codes as digits.
      add_byte(8'hFF, 1'b0);
      add_byte(DASH_CODE, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(numeral(0), 1'b0);
      add_byte(numeral(9), 1'b1);
      // Two dashes, with a pop in the middle of the message. The earlier dash
      // counts as a digit of the pin.
      add_byte(numeral(1), 1'b0);
      add_known(OP_POP, 8'hFF, 1'b1, '{ST_POPPED, 16'sd3, 16'sd1, 4'd1});
      add_byte(DASH_CODE, 1'b0);
      add_byte(numeral(2), 1'b0);
      add_byte(DASH_CODE, 1'b0);
      add_byte(numeral(3), 1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].eom,
                   directed_rows[i].has_fixed, directed_rows[i].fixed);

      // The random part alternates between a fill phase with few pops, which
      // drives the store into overflow, and a drain phase with many pops,
      // which empties it and pops on empty.
      while (items_sent < ITEM_TARGET) begin
         pop_percent = ((items_sent / 120) % 2 == 0) ? 12 : 55;
         if ($urandom_range(0, 99) < pop_percent) begin
            send_item(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, none);
         end else begin
            body.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               // Well-formed pin-value command that fits the buffer.
               pin_len = $urandom_range(1, 3);
               repeat (pin_len) body.push_back(numeral($urandom_range(0, 9)));
               body.push_back(DASH_CODE);
               repeat ($urandom_range(0, 5 - pin_len))
                  body.push_back(numeral($urandom_range(0, 9)));
            end else if (kind < 78) begin
               // Too long for the buffer.
               len = $urandom_range(7, 9);
               body.push_back(numeral($urandom_range(0, 9)));
               body.push_back(DASH_CODE);
               while (body.size() < len) body.push_back(numeral($urandom_range(0, 9)));
            end else if (kind < 84) begin
               // Leading dash.
               body.push_back(DASH_CODE);
               repeat ($urandom_range(0, 4)) body.push_back(numeral($urandom_range(0, 9)));
            end else if (kind < 90) begin
               // Digits and dashes mixed, often with several dashes.
               len = $urandom_range(2, 6);
               repeat (len)
                  body.push_back($urandom_range(0, 1) ? DASH_CODE
                                                      : numeral($urandom_range(0, 9)));
            end else begin
               // Raw noise over the whole byte range.
               len = $urandom_range(1, 7);
               repeat (len) body.push_back(8'($urandom_range(0, 255)));
            end
            // Now and then a pop lands in the middle of the message.
            split = ($urandom_range(0, 9) == 0) ? $urandom_range(1, body.size()) : 0;
            foreach (body[i]) begin
               if (split != 0 && i == split)
                  send_item(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'b0, none);
               send_item(OP_BYTE, body[i], i == body.size() - 1, 1'b0, none);
            end
         end
      end
      push <= 1'b0;

      // Drain, then allow for the pipeline delay and the receiver's stalls
      // so that any stray result still gets caught.
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d transactions (%0d directed), checked %0d results, %0d input stalls.",
               items_sent, directed_rows.size(), results_seen, full_cycles);
      $display("Results: %0d queued, %0d malformed, %0d dropped, %0d popped, %0d empty pops.",
               status_tally[ST_QUEUED], status_tally[ST_MALFORMED], status_tally[ST_FULL],
               status_tally[ST_POPPED], status_tally[ST_EMPTY]);
      if (mismatch_count == 0) begin
         $display("pin_value_command_parser_queue_top verification clean");
      end else begin
         $display("pin_value_command_parser_queue_top verification failed");
      end
      $finish;
   end

   // Result side: pops after a random stall, and checks each result
   // against the oldest expectation. Now and then it holds off for a long
   // stretch so the block backs up and raises full.
   initial begin
      int      stall;
      int      next_hold;
      rsp_type want;
      next_hold = 200;
      while (reset) @(posedge clock);
      forever begin
         if (results_seen == next_hold) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            next_hold += 400;
         end
         stall = (results_seen % 180 < 40) ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         results_seen++;
         status_tally[rsp_status]++;
         if (expected_results.size() == 0) begin
            $error("unexpected result: status %0d, pin %0d, level %0d, count %0d",
                   rsp_status, rsp_pin_number, rsp_output_level, rsp_queue_count);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_pin_number !== want.pin) begin
               $error("rsp_pin_number: expected %0d, got %0d", want.pin, rsp_pin_number);
               mismatch_count++;
            end
            if (rsp_output_level !== want.level) begin
               $error("rsp_output_level: expected %0d, got %0d", want.level, rsp_output_level);
               mismatch_count++;
            end
            if (rsp_queue_count !== want.count) begin
               $error("rsp_queue_count: expected %0d, got %0d", want.count, rsp_queue_count);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog. A correct run ends far sooner than this.
   initial begin
      #2000000;
      $display("pin_value_command_parser_queue_top verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/pvcq_pkg.sv
design/pvcq_fifo.sv
design/pvcq_front.sv
design/pvcq_back.sv
design/pin_value_command_parser_queue_top.sv
test/tb_top.sv
